FILE: rtl/core/itt_pkg.sv
// Package for the interval timer table: item payload structs, slot entry layout
// and the opcode, result-kind and timer-mode codes.
// No dependencies; the top level refers to it by scoped names.
package itt_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned CFG_W   = 10;
  localparam int unsigned COUNT_W = 5;

  localparam logic [CFG_W-1:0] AFB_RESET = 10'd10;

  // Opcodes of an input item.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_FIRED  = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  // Timer modes. The unused fourth code behaves as periodic.
  localparam logic [1:0] MODE_PERIODIC = 2'd0;
  localparam logic [1:0] MODE_ONE_SHOT = 2'd1;
  localparam logic [1:0] MODE_DESTROY  = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [TIME_W-1:0] interval;
    logic [1:0]        timer_mode;
    logic              has_handler;
    logic [ID_W-1:0]   target_id;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic               refused;
    logic [ID_W-1:0]    result_id;
    logic [COUNT_W-1:0] fired_count;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [1:0]        mode;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] last_fire;
  } slot_t;

endpackage

FILE: rtl/core/interval_timer_table_top.sv
// Top level of the interval timer table: sequencer, slot memory and delete queue.
// Depends on itt_pkg for payload structs, the slot layout and the codes.
// The block serves one item at a time. An add, a delete, or a tick on an empty table
// passes through the accepting state and one state that decides the item and loads
// its result into the output register. A tick on a table holding timers first applies
// each queued delete, then walks the table to fire timers and reports its count; it
// also waits whenever the consumer has not yet taken an earlier result. The slot memory
// has one registered read port, so every slot visit reads the entry in one state and
// evaluates it and writes it back in the following state. Each queued delete costs one
// full pass over the table that compacts it in place, and the firing walk is a second
// compacting pass that restamps periodic timers and drops fired one-shot timers.
// Timers always sit in a dense prefix of the memory in order of addition, so no clearing
// pass is needed after reset. The input is ready only while the sequencer is idle;
// results leave through an output register, so a finished item can wait there while
// the next one is being accepted.
module interval_timer_table_top #(
  parameter int unsigned TIMER_SLOTS        = 16,
  parameter int unsigned DELETE_QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  itt_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output itt_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [itt_pkg::CFG_W-1:0]     cfg_wdata
);

  // Counters that must hold the depth itself, and the narrower memory addresses.
  localparam int unsigned CW   = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned SAW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int unsigned QCW  = $clog2(DELETE_QUEUE_DEPTH + 1);
  localparam int unsigned QAW  = (DELETE_QUEUE_DEPTH > 1) ? $clog2(DELETE_QUEUE_DEPTH) : 1;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,  // waiting for an input item
    S_OP   = 8'b0000_0010,  // decode the held item; adds and deletes finish here
    S_QRD  = 8'b0000_0100,  // read one queued delete id
    S_SRD  = 8'b0000_1000,  // delete pass: read the next slot or close the pass
    S_SEV  = 8'b0001_0000,  // delete pass: compare, shift down after the match
    S_WRD  = 8'b0010_0000,  // firing walk: read the next slot or finish
    S_WEV  = 8'b0100_0000,  // firing walk: decide, report, write back
    S_DONE = 8'b1000_0000   // report the tick count
  } state_t;

  // Control registers.
  state_t                        state_r, state_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;      // timers in the table
  logic [QCW-1:0]                qcnt_r, qcnt_nxt;    // queued deletes
  logic [QCW-1:0]                qi_r, qi_nxt;        // queue entry being applied
  logic [CW-1:0]                 idx_r, idx_nxt;      // slot being read
  logic [CW-1:0]                 wptr_r, wptr_nxt;    // compaction write pointer
  logic                          matched_r, matched_nxt;
  logic [itt_pkg::COUNT_W-1:0]   fired_r, fired_nxt;
  logic [itt_pkg::ID_W-1:0]      id_ctr_r, id_ctr_nxt;
  logic [itt_pkg::CFG_W-1:0]     afb_r, afb_nxt;
  logic                          out_valid_r, out_valid_nxt;

  // Payload registers.
  itt_pkg::in_item_t             item_r, item_nxt;
  itt_pkg::out_item_t            out_data_r, out_data_nxt;

  // Slot memory and delete queue, each with a registered read port.
  itt_pkg::slot_t                slot_mem [TIMER_SLOTS];
  itt_pkg::slot_t                slot_rd_r;
  logic [itt_pkg::ID_W-1:0]      q_mem [DELETE_QUEUE_DEPTH];
  logic [itt_pkg::ID_W-1:0]      q_rd_r;

  logic                          slot_we, slot_re;
  logic [SAW-1:0]                slot_waddr;
  itt_pkg::slot_t                slot_wdata;
  logic                          q_we, q_re;

  logic                          out_free;
  logic                          emit;
  itt_pkg::out_item_t            emit_data;

  // Evaluation of the slot under the walk.
  logic [itt_pkg::TIME_W-1:0]    elapsed;
  logic                          fire;
  logic [CW-1:0]                 idx_dec;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign elapsed = item_r.now_time - slot_rd_r.last_fire;
  assign fire    = (slot_rd_r.mode != itt_pkg::MODE_DESTROY) &&
                   ((elapsed >= slot_rd_r.period) ||
                    (slot_rd_r.period < {{(itt_pkg::TIME_W - itt_pkg::CFG_W){1'b0}}, afb_r}));
  assign idx_dec = idx_r - CW'(1);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    qcnt_nxt     = qcnt_r;
    qi_nxt       = qi_r;
    idx_nxt      = idx_r;
    wptr_nxt     = wptr_r;
    matched_nxt  = matched_r;
    fired_nxt    = fired_r;
    id_ctr_nxt   = id_ctr_r;
    afb_nxt      = cfg_we ? cfg_wdata : afb_r;
    item_nxt     = item_r;
    emit         = 1'b0;
    emit_data    = '0;
    slot_we      = 1'b0;
    slot_re      = 1'b0;
    slot_waddr   = idx_r[SAW-1:0];
    slot_wdata   = slot_rd_r;
    q_we         = 1'b0;
    q_re         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_OP;
        end
      end

      S_OP: begin
        case (item_r.opcode)
          itt_pkg::OP_ADD: begin
            if (out_free) begin
              emit                  = 1'b1;
              emit_data.result_kind = itt_pkg::KIND_ADD;
              emit_data.last_of_run = 1'b1;
              if (item_r.has_handler && (cnt_r < CW'(TIMER_SLOTS))) begin
                // The table is a dense prefix, so the free slot is at the count.
                id_ctr_nxt           = id_ctr_r + 32'd1;
                slot_we              = 1'b1;
                slot_waddr           = cnt_r[SAW-1:0];
                slot_wdata.id        = id_ctr_r + 32'd1;
                slot_wdata.mode      = item_r.timer_mode;
                slot_wdata.period    = item_r.interval;
                slot_wdata.last_fire = item_r.now_time;
                cnt_nxt              = cnt_r + CW'(1);
                emit_data.result_id  = id_ctr_r + 32'd1;
              end else begin
                emit_data.refused = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end

          itt_pkg::OP_DELETE: begin
            if (out_free) begin
              emit                  = 1'b1;
              emit_data.result_kind = itt_pkg::KIND_DELETE;
              emit_data.last_of_run = 1'b1;
              if ((item_r.target_id != '0) && (qcnt_r < QCW'(DELETE_QUEUE_DEPTH))) begin
                q_we     = 1'b1;
                qcnt_nxt = qcnt_r + QCW'(1);
              end else begin
                emit_data.refused = 1'b1;
              end
              state_nxt = S_IDLE;
            end
          end

          itt_pkg::OP_TICK: begin
            fired_nxt = '0;
            qi_nxt    = '0;
            idx_nxt   = '0;
            wptr_nxt  = '0;
            if (cnt_r == '0) begin
              // An empty table leaves the queued deletes in place.
              if (out_free) begin
                emit                  = 1'b1;
                emit_data.result_kind = itt_pkg::KIND_DONE;
                emit_data.last_of_run = 1'b1;
                state_nxt             = S_IDLE;
              end
            end else if (qcnt_r == '0) begin
              state_nxt = S_WRD;
            end else begin
              state_nxt = S_QRD;
            end
          end

          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_QRD: begin
        q_re        = 1'b1;
        idx_nxt     = '0;
        matched_nxt = 1'b0;
        state_nxt   = S_SRD;
      end

      S_SRD: begin
        if (idx_r == cnt_r) begin
          if (matched_r) begin
            cnt_nxt = cnt_r - CW'(1);
          end
          qi_nxt = qi_r + QCW'(1);
          if ((qi_r + QCW'(1)) == qcnt_r) begin
            idx_nxt   = '0;
            wptr_nxt  = '0;
            state_nxt = S_WRD;
          end else begin
            state_nxt = S_QRD;
          end
        end else begin
          slot_re   = 1'b1;
          state_nxt = S_SEV;
        end
      end

      S_SEV: begin
        if (matched_r) begin
          // Close the gap left by the removed timer.
          slot_we    = 1'b1;
          slot_waddr = idx_dec[SAW-1:0];
          slot_wdata = slot_rd_r;
        end else if (slot_rd_r.id == q_rd_r) begin
          matched_nxt = 1'b1;
        end
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SRD;
      end

      S_WRD: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_DONE;
        end else begin
          slot_re   = 1'b1;
          state_nxt = S_WEV;
        end
      end

      S_WEV: begin
        if (!fire || out_free) begin
          if (fire) begin
            emit                  = 1'b1;
            emit_data.result_kind = itt_pkg::KIND_FIRED;
            emit_data.result_id   = slot_rd_r.id;
            fired_nxt             = fired_r + itt_pkg::COUNT_W'(1);
          end
          if (!(fire && (slot_rd_r.mode == itt_pkg::MODE_ONE_SHOT))) begin
            // Kept timers move down to the write pointer; fired ones are restamped.
            slot_we    = 1'b1;
            slot_waddr = wptr_r[SAW-1:0];
            slot_wdata = slot_rd_r;
            if (fire) begin
              slot_wdata.last_fire = item_r.now_time;
            end
            wptr_nxt = wptr_r + CW'(1);
          end
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_WRD;
        end
      end

      S_DONE: begin
        if (out_free) begin
          emit                  = 1'b1;
          emit_data.result_kind = itt_pkg::KIND_DONE;
          emit_data.fired_count = fired_r;
          emit_data.last_of_run = 1'b1;
          cnt_nxt               = wptr_r;
          qcnt_nxt              = '0;
          state_nxt             = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register: loaded on a new result, emptied when the consumer takes it.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = emit_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      qcnt_r      <= '0;
      qi_r        <= '0;
      idx_r       <= '0;
      wptr_r      <= '0;
      matched_r   <= 1'b0;
      fired_r     <= '0;
      id_ctr_r    <= '0;
      afb_r       <= itt_pkg::AFB_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      qcnt_r      <= qcnt_nxt;
      qi_r        <= qi_nxt;
      idx_r       <= idx_nxt;
      wptr_r      <= wptr_nxt;
      matched_r   <= matched_nxt;
      fired_r     <= fired_nxt;
      id_ctr_r    <= id_ctr_nxt;
      afb_r       <= afb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  // Slot memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (slot_re) begin
      slot_rd_r <= slot_mem[idx_r[SAW-1:0]];
    end
  end

  // Delete queue: filled at the count, read in order during a tick.
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[qcnt_r[QAW-1:0]] <= item_r.target_id;
    end
    if (q_re) begin
      q_rd_r <= q_mem[qi_r[QAW-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(TIMER_SLOTS))
    else $error("timer count exceeds the table size");

  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= QCW'(DELETE_QUEUE_DEPTH))
    else $error("delete queue count exceeds its depth");

  a_walk_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WEV || state_r == S_WRD || state_r == S_DONE) |-> wptr_r <= idx_r)
    else $error("compaction write pointer ran ahead of the read index");

  a_tick_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> cnt_r <= $past(cnt_r))
    else $error("a tick grew the timer table");
`endif

endmodule

FILE: bench/itt_checker.sv
// Checker for the interval timer table: watches both channels and the threshold port,
// keeps its own copy of the timer table and compares every result item in order.
// Depends on itt_pkg for the payload structs, the slot layout and the codes.
`timescale 1ns / 100ps

module itt_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  itt_pkg::in_item_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  itt_pkg::out_item_t        out_data,
  input  logic                      cfg_we,
  input  logic [itt_pkg::CFG_W-1:0] cfg_wdata,
  output int unsigned               fail_count,
  output int unsigned               outstanding
);
  import itt_pkg::*;

  localparam int unsigned SLOT_COUNT   = 16;
  localparam int unsigned DELETE_DEPTH = 16;

  slot_t              timer_table[$];
  logic [ID_W-1:0]    delete_posts[DELETE_DEPTH];
  logic [ID_W-1:0]    last_id;
  logic [CFG_W-1:0]   fire_below;
  out_item_t          pending_results[$];
  int unsigned        fails = 0;

  assign fail_count = fails;

  task automatic clear_table();
    int unsigned k;
    timer_table.delete();
    pending_results.delete();
    for (k = 0; k < DELETE_DEPTH; k++) delete_posts[k] = '0;
    last_id    = '0;
    fire_below = AFB_RESET;
  endtask

  task automatic push_result(input logic [1:0] kind, input logic refused,
                             input logic [ID_W-1:0] id, input logic [COUNT_W-1:0] count,
                             input logic last);
    out_item_t r;
    r.result_kind = kind;
    r.refused     = refused;
    r.result_id   = id;
    r.fired_count = count;
    r.last_of_run = last;
    pending_results.push_back(r);
  endtask

  task automatic predict_results(input in_item_t it);
    int unsigned        i;
    int unsigned        q;
    logic               done;
    logic [COUNT_W-1:0] fired;
    logic [TIME_W-1:0]  elapsed;
    slot_t              s;
    fired = '0;
    case (it.opcode)
      OP_ADD: begin
        if (!it.has_handler || timer_table.size() >= SLOT_COUNT) begin
          push_result(KIND_ADD, 1'b1, '0, '0, 1'b1);
        end else begin
          last_id     = last_id + 1'b1;
          s.id        = last_id;
          s.mode      = it.timer_mode;
          s.period    = it.interval;
          s.last_fire = it.now_time;
          timer_table.push_back(s);
          push_result(KIND_ADD, 1'b0, last_id, '0, 1'b1);
        end
      end
      OP_DELETE: begin
        done = 1'b0;
        if (it.target_id != '0) begin
          for (q = 0; q < DELETE_DEPTH; q++) begin
            if (!done && delete_posts[q] == '0) begin
              delete_posts[q] = it.target_id;
              done = 1'b1;
            end
          end
        end
        push_result(KIND_DELETE, !done, '0, '0, 1'b1);
      end
      OP_TICK: begin
        // An empty table leaves the posted deletes where they are.
        if (timer_table.size() != 0) begin
          for (q = 0; q < DELETE_DEPTH; q++) begin
            if (delete_posts[q] != '0) begin
              done = 1'b0;
              for (i = 0; i < timer_table.size(); i++) begin
                if (!done && timer_table[i].id == delete_posts[q]) begin
                  timer_table.delete(i);
                  done = 1'b1;
                end
              end
              delete_posts[q] = '0;
            end
          end
          i = 0;
          while (i < timer_table.size()) begin
            s       = timer_table[i];
            elapsed = it.now_time - s.last_fire;
            if (s.mode != MODE_DESTROY &&
                (elapsed >= s.period || s.period < TIME_W'(fire_below))) begin
              fired = fired + 1'b1;
              push_result(KIND_FIRED, 1'b0, s.id, '0, 1'b0);
              if (s.mode == MODE_ONE_SHOT) begin
                timer_table.delete(i);
              end else begin
                s.last_fire    = it.now_time;
                timer_table[i] = s;
                i++;
              end
            end else begin
              i++;
            end
          end
        end
        push_result(KIND_DONE, 1'b0, '0, fired, 1'b1);
      end
      default: begin
      end
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_results.size() == 0) begin
      $error("unexpected result item: kind %0d, id 0x%0h", got.result_kind, got.result_id);
      fails++;
    end else begin
      want = pending_results.pop_front();
      compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
      compare_field("refused", 32'(want.refused), 32'(got.refused));
      compare_field("result_id", want.result_id, got.result_id);
      compare_field("fired_count", 32'(want.fired_count), 32'(got.fired_count));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
      outstanding <= 0;
    end else begin
      if (cfg_we) fire_below = cfg_wdata;
      if (in_valid && in_ready) predict_results(in_data);
      if (out_valid && out_ready) check_result(out_data);
      outstanding <= pending_results.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
// Testbench top for the interval timer table: clock, reset, item stimulus, threshold
// writes, random idling on both channels, watchdog and the final verdict.
// Depends on itt_pkg, interval_timer_table_top and the itt_checker module.
`timescale 1ns / 100ps

module tb_top;
  import itt_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 3;
  // The worst tick (full table, full delete queue) accepts no item while it runs,
  // and a receiver hold-off may sit on top of it.
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES  = 50;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned IDLE_PCT       = 26;
  // The fourth opcode is not in the package; the block must ignore it.
  localparam logic [1:0]  OP_IGNORED     = 2'd3;
  localparam logic [1:0]  MODE_SPARE     = 2'd3;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_item_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  int unsigned        fail_count;
  int unsigned        outstanding;
  int unsigned        quiet_cycles = 0;

  // steady switches off random idling on both sides; hold_request asks the receiver
  // for one long hold-off.
  bit                 steady       = 1'b0;
  bit                 hold_request = 1'b0;

  // Running time stamp and a rough count of ids handed out, used to aim deletes at
  // timers that probably exist.
  logic [TIME_W-1:0]  clock_now  = '0;
  logic [ID_W-1:0]    ids_issued = '0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  interval_timer_table_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  itt_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  // The watchdog restarts whenever an item moves on either channel. A run that sits
  // still for too long is a hang.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // The receiver takes result items at random, except in steady stretches. When a
  // hold-off is asked for, it holds out_ready low so the
  // output register fills and the block stops taking input.
  initial begin : receiver
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready    <= 1'b0;
        hold_request <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Offers one item. Random idle cycles come first, then valid rises with the payload
  // and stays up until the item is accepted. The task returns at the accepting edge
  // with valid still high, so the next call either lowers it or reuses it.
  task automatic send_item(input in_item_t item);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    if (item.opcode == OP_ADD && item.has_handler) ids_issued = ids_issued + 1'b1;
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [TIME_W-1:0] interval,
                             input logic [1:0] mode, input logic handler,
                             input logic [ID_W-1:0] target, input logic [TIME_W-1:0] now);
    in_item_t it;
    it.opcode      = op;
    it.interval    = interval;
    it.timer_mode  = mode;
    it.has_handler = handler;
    it.target_id   = target;
    it.now_time    = now;
    send_item(it);
  endtask

  // Stops offering items and waits until every expected result item has arrived.
  // The first edge lets the checker count the last accepted item.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Threshold writes happen only with the block idle: all results in, then a settling
  // wait in case an ignored item is still being dropped.
  task automatic retune(input logic [CFG_W-1:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Builds one random item. The weights pick the opcode, and whatever is left over goes
  // to the ignored opcode. Intervals are mostly short so that timers fire, with some
  // near the threshold range and some anywhere in 32 bits. Time moves forward in small
  // steps with an occasional large jump that wraps.
  task automatic build_random_item(input int unsigned w_add, input int unsigned w_del,
                                   input int unsigned w_tick, output in_item_t it);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < w_add)                       it.opcode = OP_ADD;
    else if (pick < w_add + w_del)          it.opcode = OP_DELETE;
    else if (pick < w_add + w_del + w_tick) it.opcode = OP_TICK;
    else                                    it.opcode = OP_IGNORED;

    pick = $urandom_range(0, 99);
    if (pick < 80)      it.interval = $urandom_range(0, 60);
    else if (pick < 90) it.interval = $urandom_range(0, 1100);
    else                it.interval = $urandom();

    pick = $urandom_range(0, 99);
    if (pick < 50)      it.timer_mode = MODE_PERIODIC;
    else if (pick < 75) it.timer_mode = MODE_ONE_SHOT;
    else if (pick < 90) it.timer_mode = MODE_DESTROY;
    else                it.timer_mode = MODE_SPARE;

    it.has_handler = ($urandom_range(0, 99) >= 8);

    pick = $urandom_range(0, 99);
    if (pick < 85)      it.target_id = $urandom_range(1, ids_issued + 2);
    else if (pick < 92) it.target_id = '0;
    else                it.target_id = $urandom();

    if ($urandom_range(0, 99) < 3) clock_now = clock_now + $urandom();
    else                           clock_now = clock_now + $urandom_range(0, 40);
    it.now_time = clock_now;
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned w_add,
                           input int unsigned w_del, input int unsigned w_tick);
    in_item_t it;
    repeat (count) begin
      build_random_item(w_add, w_del, w_tick, it);
      send_item(it);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, with the threshold at its reset value of 10.
    // A tick on an empty table answers with a zero count.
    send_fields(OP_TICK, '0, MODE_PERIODIC, 1'b0, '0, '0);
    // A delete of id zero is refused; an id nobody owns is queued and later dropped.
    send_fields(OP_DELETE, '0, MODE_PERIODIC, 1'b0, '0, '0);
    send_fields(OP_DELETE, '0, MODE_PERIODIC, 1'b0, '1, '0);
    // An add without a handler is refused.
    send_fields(OP_ADD, 32'd5, MODE_PERIODIC, 1'b0, '0, '0);
    // Timers of every mode, at the interval extremes. The last one is stamped just
    // before the time stamp wraps.
    send_fields(OP_ADD, '0, MODE_PERIODIC, 1'b1, '0, '0);
    send_fields(OP_ADD, '1, MODE_ONE_SHOT, 1'b1, '0, 32'hFFFF_FFF0);
    send_fields(OP_ADD, 32'd3, MODE_DESTROY, 1'b1, '0, '0);
    send_fields(OP_ADD, 32'd100, MODE_SPARE, 1'b1, '0, '0);
    send_fields(OP_ADD, 32'd20, MODE_ONE_SHOT, 1'b1, '0, 32'hFFFF_FFF8);
    // The ignored opcode with every other bit set.
    send_item(in_item_t'('1));
    // This tick drains the unknown delete and fires across the time wrap.
    send_fields(OP_TICK, '0, MODE_PERIODIC, 1'b0, '0, 32'h0000_000C);
    // The same id posted twice: the second entry finds nothing left to remove.
    send_fields(OP_DELETE, '0, MODE_PERIODIC, 1'b0, 32'd1, '0);
    send_fields(OP_DELETE, '0, MODE_PERIODIC, 1'b0, 32'd1, '0);
    send_fields(OP_TICK, '0, MODE_PERIODIC, 1'b0, '0, '1);
    send_fields(OP_ADD, '1, MODE_SPARE, 1'b1, '1, '1);
    // Intervals just below and exactly at the threshold.
    send_fields(OP_ADD, 32'd9, MODE_ONE_SHOT, 1'b1, '0, 32'd5);
    send_fields(OP_ADD, 32'd10, MODE_PERIODIC, 1'b1, '0, 32'd5);
    send_fields(OP_TICK, '0, MODE_PERIODIC, 1'b0, '0, 32'd6);
    send_fields(OP_TICK, '0, MODE_PERIODIC, 1'b0, '0, 32'd15);
    clock_now = 32'd15;

    // No interval is below a threshold of zero, so only elapsed time fires timers.
    retune('0);
    run_phase(15, 45, 15, 35);

    // Every short interval fires at the top threshold. Mostly adds, with no idling,
    // so the table fills and further adds are refused.
    retune(10'd1023);
    steady <= 1'b1;
    run_phase(25, 75, 5, 15);
    steady <= 1'b0;

    // The receiver holds off while the sender keeps offering ticks and adds against
    // a full table, so results pile up and the input stalls.
    hold_request <= 1'b1;
    run_phase(12, 40, 10, 45);

    // Mostly deletes, so the delete queue fills and later ones are refused. Halfway
    // through, the sender waits for every result before it goes on.
    retune(10'($urandom_range(0, 1023)));
    run_phase(11, 5, 92, 0);
    wait_for_results();
    run_phase(11, 5, 92, 0);

    // Back at the reset threshold with a balanced mix; the first tick here applies
    // a full delete queue to a crowded table.
    retune(AFB_RESET);
    run_phase(12, 40, 20, 35);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/itt_pkg.sv
rtl/core/interval_timer_table_top.sv
bench/itt_checker.sv
bench/tb_top.sv
